/* src/rsa_pkg.sv */
package rsa_pkg;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_CLEAR = 4'd2,
        OP_DUP   = 4'd3,
        OP_SWAP  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_DIV   = 4'd8
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DIV0      = 3'd1,
        ST_NEED_TWO  = 3'd2,
        ST_SWAP_TWO  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_DUP_EMPTY = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    // stack action applied to every cell in the same cycle
    typedef enum logic [2:0] {
        SH_HOLD = 3'd0,
        SH_PUSH = 3'd1,
        SH_POP  = 3'd2,
        SH_SWAP = 3'd3,
        SH_RES  = 3'd4
    } shift_t;

    typedef struct packed {
        shift_t      op;
        logic [31:0] value;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    localparam int unsigned DIV_STEPS = 32;

endpackage

/* src/rsa_cell.sv */
// One stack slot. Cell 0 is the top; data moves down on push, up on pop.
module rsa_cell
    import rsa_pkg::*;
(
    input  logic        clk,
    input  cell_ctl_t   ctl,
    input  logic        is_top,
    input  logic        is_second,
    input  logic [31:0] above,
    input  logic [31:0] below,
    output logic [31:0] data
);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            SH_PUSH: data_next = is_top ? ctl.value : above;
            SH_POP:  data_next = below;
            SH_SWAP:
            begin
                if (is_top)
                    data_next = below;
                else if (is_second)
                    data_next = above;
            end
            // result replaces second, top drops out
            SH_RES:  data_next = is_top ? ctl.value : below;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* src/rsa_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module rsa_divider
    import rsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, div_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            div_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd1);
    assign quotient = neg_reg ? (32'd0 - quo_next) : quo_next;

endmodule

/* src/rpn_stack_alu.sv */
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: opcode[3:0], push_value[35:4], zero fill to 40 bits
// m_axis  | out | tdata: status[2:0], top_value[34:3], top_valid[35],
//         |     |        stack_depth[40:36], zero fill to 48 bits
// Push, pop, clear, dup, swap, add, sub and mul update the cell row in the
// accept cycle, then present the result in S_OUT.
// Divide passes through the accept cycle, 32 restoring steps of one bit
// each in S_DIV, and S_OUT to present the result.
// Reset empties the stack at once; cell contents are not cleared.
// A result held by m_axis_tready low blocks the next input item.
module rpn_stack_alu
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, push_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, top_value, top_valid, stack_depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    status_t       status_reg, status_next;
    cell_ctl_t     ctl;
    logic [31:0]   data [STACK_DEPTH];
    logic [31:0]   a, b;
    logic [3:0]    op;
    logic [31:0]   pv;
    logic          div_start, div_done;
    logic [31:0]   quotient;
    logic          accept;

    assign op     = s_axis_tdata[3:0];
    assign pv     = s_axis_tdata[35:4];
    assign a      = data[0];
    assign b      = data[1];
    assign accept = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++)
        begin : g_cell
            rsa_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .is_top    (g == 0),
                .is_second (g == 1),
                .above     (g == 0 ? 32'd0 : data[(g == 0) ? 0 : g - 1]),
                .below     (g == STACK_DEPTH - 1 ? 32'd0
                            : data[(g == STACK_DEPTH - 1) ? g : g + 1]),
                .data      (data[g])
            );
        end
    endgenerate

    rsa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a),
        .divisor  (b),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = div_start ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        ctl         = '{op: SH_HOLD, value: 32'd0};
        count_next  = count_reg;
        status_next = status_reg;
        div_start   = 1'b0;
        if (state_reg == S_IDLE && accept)
        begin
            status_next = ST_OK;
            case (op)
                OP_PUSH, OP_DUP:
                begin
                    if (op == OP_DUP && count_reg == '0)
                        status_next = ST_DUP_EMPTY;
                    else if (count_reg == CW'(STACK_DEPTH))
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.op     = SH_PUSH;
                        ctl.value  = (op == OP_PUSH) ? pv : a;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_POP, OP_CLEAR:
                begin
                    if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else if (op == OP_POP)
                    begin
                        ctl.op     = SH_POP;
                        count_next = count_reg - CW'(1);
                    end
                    else
                        count_next = '0;
                end
                OP_SWAP:
                begin
                    if (count_reg < CW'(2))
                        status_next = ST_SWAP_TWO;
                    else
                        ctl.op = SH_SWAP;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (count_reg < CW'(2))
                        status_next = ST_NEED_TWO;
                    else if (op == OP_DIV)
                    begin
                        if (b == 32'd0)
                            status_next = ST_DIV0;
                        else
                            div_start = 1'b1;
                    end
                    else
                    begin
                        ctl.op     = SH_RES;
                        count_next = count_reg - CW'(1);
                        case (op)
                            OP_ADD:  ctl.value = a + b;
                            OP_SUB:  ctl.value = a - b;
                            default: ctl.value = 32'(a * b);
                        endcase
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == S_DIV && div_done)
        begin
            ctl.op     = SH_RES;
            ctl.value  = quotient;
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {7'd0, 5'(count_reg), (count_reg != '0),
                            (count_reg != '0) ? a : 32'd0, status_reg};

endmodule

/* bench/rpn_stack_alu_test.sv */
`timescale 1ns / 100ps

module rpn_stack_alu_test;
    import rsa_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        status_t     status;
        logic [31:0] top_value;
        logic        top_valid;
        logic [4:0]  stack_depth;
    } alu_result_t;

    class stack_scoreboard;
        logic [31:0]  cells[DEPTH];
        int unsigned  count;
        alu_result_t  pending[$];
        int unsigned  errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_input(logic [3:0] op, logic [31:0] value);
            status_t     st;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            alu_result_t res;
            st = ST_OK;
            case (op)
                OP_PUSH:
                    if (count >= DEPTH) st = ST_FULL;
                    else begin cells[count] = value; count++; end
                OP_POP:
                    if (count == 0) st = ST_EMPTY;
                    else count--;
                OP_CLEAR:
                    if (count == 0) st = ST_EMPTY;
                    else count = 0;
                OP_DUP:
                    if (count == 0) st = ST_DUP_EMPTY;
                    else if (count >= DEPTH) st = ST_FULL;
                    else begin cells[count] = cells[count-1]; count++; end
                OP_SWAP:
                    if (count < 2) st = ST_SWAP_TWO;
                    else begin
                        a = cells[count-1];
                        cells[count-1] = cells[count-2];
                        cells[count-2] = a;
                    end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    if (count < 2) st = ST_NEED_TWO;
                    else begin
                        a = cells[count-1];
                        b = cells[count-2];
                        if (op == OP_DIV && b == 0) st = ST_DIV0;
                        else begin
                            case (op)
                                OP_ADD:  r = a + b;
                                OP_SUB:  r = a - b;
                                OP_MUL:  r = a * b;
                                default: r = quotient(a, b);
                            endcase
                            count--;
                            cells[count-1] = r;
                        end
                    end
                default: ;
            endcase
            res.status = st;
            res.top_valid = (count > 0);
            res.top_value = (count > 0) ? cells[count-1] : 32'd0;
            res.stack_depth = count[4:0];
            pending.push_back(res);
        endfunction

        function void check_result(logic [47:0] data);
            alu_result_t got;
            alu_result_t exp;
            got.status = status_t'(data[2:0]);
            got.top_value = data[34:3];
            got.top_valid = data[35];
            got.stack_depth = data[40:36];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.top_value != exp.top_value) begin
                $display("%0t: top_value expected %h actual %h", $time, exp.top_value,
                         got.top_value);
                errors++;
            end
            if (got.top_valid != exp.top_valid) begin
                $display("%0t: top_valid expected %b actual %b", $time, exp.top_valid,
                         got.top_valid);
                errors++;
            end
            if (got.stack_depth != exp.stack_depth) begin
                $display("%0t: stack_depth expected %0d actual %0d", $time, exp.stack_depth,
                         got.stack_depth);
                errors++;
            end
            if (data[47:41] != 0) begin
                $display("%0t: fill bits expected 0 actual %h", $time, data[47:41]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    stack_scoreboard board;
    bit stimulus_done;

    rpn_stack_alu #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // driven at the falling edge, so blocking updates cannot race the sampling edge
    task automatic send_op(logic [3:0] op, logic [31:0] value);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, value, op};
        do @(posedge clk); while (!s_axis_tready);
        board.note_input(op, value);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall per transfer, with stall-free stretches
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            repeat (stall) @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata);
            @(negedge clk);
            m_axis_tready <= 1'b0;
        end
    end

    initial
    begin
        int k;
        int sel;
        logic [3:0] op;
        board = new();
        stimulus_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty-stack errors and undefined opcodes
        send_op(OP_POP, 32'd0);
        send_op(OP_CLEAR, 32'd0);
        send_op(OP_DUP, 32'd0);
        send_op(OP_SWAP, 32'd0);
        send_op(OP_ADD, 32'd0);
        send_op(4'd9, 32'hffff_ffff);
        send_op(4'd15, 32'd0);
        // most negative over minus one
        send_op(OP_PUSH, 32'hffff_ffff);
        send_op(OP_DIV, 32'd0);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_DIV, 32'd0);
        // divide by zero
        send_op(OP_PUSH, 32'd0);
        send_op(OP_SWAP, 32'd0);
        send_op(OP_DIV, 32'd0);
        send_op(OP_SUB, 32'd0);
        send_op(OP_PUSH, 32'h7fff_ffff);
        send_op(OP_MUL, 32'd0);
        send_op(OP_CLEAR, 32'd0);
        // fill past full with push and dup
        send_op(OP_PUSH, 32'h7fff_ffff);
        for (k = 0; k < DEPTH; k++) send_op(OP_DUP, 32'd0);
        send_op(OP_PUSH, 32'h1234_5678);
        send_op(OP_ADD, 32'd0);

        // hold off until the pipeline drains
        while (board.pending.size() != 0) @(negedge clk);

        for (k = 0; k < 900; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35) op = OP_PUSH;
            else if (sel < 40) op = OP_POP;
            else if (sel < 42) op = OP_CLEAR;
            else if (sel < 52) op = OP_DUP;
            else if (sel < 60) op = OP_SWAP;
            else if (sel < 70) op = OP_ADD;
            else if (sel < 78) op = OP_SUB;
            else if (sel < 86) op = OP_MUL;
            else if (sel < 97) op = OP_DIV;
            else op = $urandom_range(9, 15);
            send_op(op, pick_value());
        end
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

/* rpn_stack_alu.f */
src/rsa_pkg.sv
src/rsa_cell.sv
src/rsa_divider.sv
src/rpn_stack_alu.sv
bench/rpn_stack_alu_test.sv
